>>> rtl/rcs_pkg.sv
// Package of the return score conditioner: register codes, reset values,
// fixed-point constants and the root table of the exponential unit.
// Depends on nothing; every other file of the block imports it.
package rcs_pkg;

    // Configuration register indexes
    typedef enum logic [1:0] {
        CFG_EMA_ALPHA     = 2'd0,
        CFG_INIT_SCALE    = 2'd1,
        CFG_INIT_SCORE    = 2'd2,
        CFG_RECAL_PERIOD  = 2'd3
    } t_cfg_index;

    // Register reset values
    localparam logic [15:0] EMA_ALPHA_RST    = 16'd655;
    localparam logic [30:0] INIT_SCALE_RST   = 31'd268435;
    localparam logic [22:0] INIT_SCORE_RST   = 23'd3276800;
    localparam logic [9:0]  RECAL_PERIOD_RST = 10'd50;

    // Fixed-point constants
    localparam logic [31:0] SCALE_FLOOR = 32'd3;
    localparam logic [31:0] LN2_Q30     = 32'd744261118;
    localparam logic [31:0] LOG2E_Q16   = 32'd94548;
    localparam logic [31:0] W_SUM_Q16   = 32'd48582;
    localparam logic [31:0] W_IQR_Q16   = 32'd16954;
    localparam logic [31:0] GAIN_Q16    = 32'd29491;
    localparam logic [19:0] Z_MAX       = 20'd524288;
    localparam logic [14:0] RECIP10_Q18 = 15'd26215;
    localparam logic [9:0]  TICKS_SAT   = 10'd1023;

    localparam logic signed [25:0] SCORE_MID = 26'sd3276800;
    localparam logic signed [25:0] SCORE_MIN = 26'sd131072;
    localparam logic signed [25:0] SCORE_MAX = 26'sd6422528;
    localparam logic signed [25:0] STEP_MAX  = 26'sd196608;
    localparam logic signed [37:0] PULL_Q16  = 38'sd1966;

    // Shared divider: dividend and divisor widths
    localparam int DIV_W = 49;
    localparam int DEN_W = 34;

    // Roots 2^(-2^(k-16)) in Q0.32, from a chain of truncated square roots
    typedef logic [15:0][31:0] t_root_tab;

    function automatic logic [63:0] f_isqrt(input logic [63:0] v);
        logic [63:0] rem;
        logic [63:0] res;
        logic [63:0] b;
        int i;
        rem = v;
        res = '0;
        for (i = 31; i >= 0; i--) begin
            b = 64'd1 << (2 * i);
            if (rem >= res + b) begin
                rem = rem - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
        end
        return res;
    endfunction

    function automatic t_root_tab f_root_tab();
        t_root_tab tab;
        logic [63:0] c;
        int k;
        c = f_isqrt(64'd1 << 63);
        for (k = 15; k >= 0; k--) begin
            tab[k] = c[31:0];
            c = f_isqrt(c << 32);
        end
        return tab;
    endfunction

    localparam t_root_tab EXP_ROOT = f_root_tab();

endpackage

>>> rtl/rcs_if.sv
// Channel interfaces of the return score conditioner: tick input, result
// output and configuration write. Depends on rcs_pkg.
interface rcs_tick_if import rcs_pkg::*; ();
    logic        valid;
    logic        ready;
    logic [31:0] price;
    modport source (output valid, output price, input ready);
    modport sink   (input valid, input price, output ready);
endinterface

interface rcs_result_if import rcs_pkg::*; ();
    logic        valid;
    logic        ready;
    logic [22:0] score;
    logic        scale_frozen;
    modport source (output valid, output score, output scale_frozen, input ready);
    modport sink   (input valid, input score, input scale_frozen, output ready);
endinterface

interface rcs_cfg_if import rcs_pkg::*; ();
    logic        valid;
    logic        ready;
    t_cfg_index  index;
    logic [31:0] wdata;
    modport source (output valid, output index, output wdata, input ready);
    modport sink   (input valid, input index, input wdata, output ready);
endinterface

>>> rtl/return_score_conditioner.sv
// Return score conditioner top level: log return, windowed calibration,
// z score, tanh dial mapping and score smoothing. Depends on rcs_pkg, rcs_if.
//
//  channel   dir  handshake     payload
//  i_tick    in   valid/ready   price[31:0]
//  o_result  out  valid/ready   score[22:0], scale_frozen
//  i_cfg     in   valid/ready   index[1:0], wdata[31:0] (always ready)
//
// One tick at a time. The first tick computes the log2 only; later ticks run
// the 28 squarings of the log2 and two 49-step divisions. A recalibrating
// tick adds a rank search over the k window entries: one window memory read
// per cycle, one pass per bit of the two order statistics. Reset is
// synchronous; no clearing pass. A waiting result does not block the next
// tick, only the delivery of its own result.
module return_score_conditioner import rcs_pkg::*; #(
    parameter int WINDOW_DEPTH = 256
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    rcs_tick_if.sink           i_tick,
    rcs_cfg_if.sink            i_cfg,
    rcs_result_if.source       o_result
);

    localparam int AW = $clog2(WINDOW_DEPTH);
    localparam int CW = $clog2(WINDOW_DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C   = CW'(WINDOW_DEPTH);
    localparam logic [AW-1:0] LAST_ADDR = AW'(WINDOW_DEPTH - 1);

    typedef enum logic [29:0] {
        S_IDLE      = 30'h0000_0001,
        S_LOG_MUL   = 30'h0000_0002,
        S_LOG_FIX   = 30'h0000_0004,
        S_LOG_DONE  = 30'h0000_0008,
        S_RET_MUL   = 30'h0000_0010,
        S_RET_FIX   = 30'h0000_0020,
        S_WIN       = 30'h0000_0040,
        S_CAL_INIT  = 30'h0000_0080,
        S_CAL_SCAN  = 30'h0000_0100,
        S_CAL_DRAIN = 30'h0000_0200,
        S_CAL_BIT   = 30'h0000_0400,
        S_CAL_SUM   = 30'h0000_0800,
        S_CAL_MUL1  = 30'h0000_1000,
        S_CAL_MUL2  = 30'h0000_2000,
        S_CAL_DONE  = 30'h0000_4000,
        S_MEAN_SUB  = 30'h0000_8000,
        S_MEAN_MUL  = 30'h0001_0000,
        S_MEAN_ADD  = 30'h0002_0000,
        S_CENT      = 30'h0004_0000,
        S_DIV       = 30'h0008_0000,
        S_U_MUL     = 30'h0010_0000,
        S_Y_MUL     = 30'h0020_0000,
        S_EXP_INIT  = 30'h0040_0000,
        S_EXP_MUL   = 30'h0080_0000,
        S_EXP_FIX   = 30'h0100_0000,
        S_EXP_END   = 30'h0200_0000,
        S_SIG       = 30'h0400_0000,
        S_STEP      = 30'h0800_0000,
        S_PULL      = 30'h1000_0000,
        S_OUT       = 30'h2000_0000
    } t_state;

    t_state r_state, n_state;

    // Configuration and persistent state
    logic [15:0]        r_alpha;
    logic [9:0]         r_period;
    logic               r_have_last;
    logic [32:0]        r_last_log;
    logic [CW-1:0]      r_count;
    logic [AW-1:0]      r_head;
    logic [9:0]         r_ticks;
    logic               r_frozen;
    logic [31:0]        r_scale;
    logic signed [31:0] r_mean;
    logic [22:0]        r_held;

    // Working registers
    logic [31:0]        r_m;
    logic [4:0]         r_exp5;
    logic [27:0]        r_frac;
    logic [4:0]         r_it;
    logic [32:0]        r_dmag;
    logic               r_rneg;
    logic [30:0]        r_rmag;
    logic [CW-1:0]      r_i10, r_i90, r_less10, r_less90;
    logic [30:0]        r_v10, r_v90;
    logic [4:0]         r_bit;
    logic [AW-1:0]      r_j;
    logic               r_rd_vld;
    logic [30:0]        r_rd_data;
    logic [31:0]        r_sum, r_iqr;
    logic [47:0]        r_acc;
    logic [31:0]        r_dabs;
    logic               r_dneg;
    logic               r_cneg;
    logic [DEN_W:0]     r_rem;
    logic [DIV_W-1:0]   r_quo;
    logic [DEN_W-1:0]   r_den;
    logic [5:0]         r_dcnt;
    logic               r_div_t;
    logic [32:0]        r_res;
    logic [15:0]        r_f;
    logic [15:0]        r_n;
    logic [3:0]         r_k;
    logic signed [25:0] r_sig, r_s;
    logic               r_near;
    logic [63:0]        r_prod;
    logic               r_out_valid;
    logic [22:0]        r_out_score;
    logic               r_out_frozen;

    // Window of return magnitudes
    logic [30:0]        r_mem [WINDOW_DEPTH];

    // Handshakes
    logic tick_acc, out_load;
    assign i_tick.ready = (r_state == S_IDLE);
    assign tick_acc     = i_tick.valid && (r_state == S_IDLE);
    assign i_cfg.ready  = 1'b1;
    assign out_load     = (r_state == S_OUT) && (!r_out_valid || o_result.ready);

    assign o_result.valid        = r_out_valid;
    assign o_result.score        = r_out_score;
    assign o_result.scale_frozen = r_out_frozen;

    // Normalize the price for the log2 loop
    logic [31:0] price_nz, m0;
    logic [4:0]  lead;
    assign price_nz = (i_tick.price == 32'd0) ? 32'd1 : i_tick.price;

    always_comb begin
        lead = '0;
        for (int b = 0; b < 32; b++) begin
            if (price_nz[b]) lead = 5'(b);
        end
    end
    assign m0 = price_nz << (5'd31 - lead);

    // Log2 and return magnitude
    logic [32:0] sq, lb, dmag_c;
    logic [63:0] ret_sum;
    logic [33:0] ret_q;
    assign sq      = r_prod[63:31];
    assign lb      = {r_exp5, r_frac};
    assign dmag_c  = (lb >= r_last_log) ? (lb - r_last_log) : (r_last_log - lb);
    assign ret_sum = r_prod + (r_dmag[32] ? {LN2_Q30, 32'd0} : 64'd0) + 64'd536870912;
    assign ret_q   = ret_sum[63:30];

    // Window bookkeeping
    logic [CW-1:0] n_cnt;
    logic [9:0]    n_tick;
    logic          win_full, recal;
    assign win_full = (r_count == DEPTH_C);
    assign n_cnt    = win_full ? r_count : r_count + 1'b1;
    assign n_tick   = (r_ticks < TICKS_SAT) ? r_ticks + 10'd1 : r_ticks;
    assign recal    = !r_frozen && ((n_cnt == DEPTH_C) || (n_tick >= r_period));

    // Order statistic ranks and bitwise search
    logic [31:0]   i10_prod, i90_prod;
    logic [CW-1:0] i10_c, i90_c;
    logic [30:0]   cand10, cand90;
    logic          scan_last;
    assign i10_prod  = 32'(r_count) * 32'(RECIP10_Q18);
    assign i90_prod  = (32'(r_count) * 32'd9) * 32'(RECIP10_Q18);
    assign i10_c     = CW'(i10_prod >> 18);
    assign i90_c     = (CW'(i90_prod >> 18) > r_count - 1'b1) ? r_count - 1'b1
                                                              : CW'(i90_prod >> 18);
    assign cand10    = r_v10 | (31'd1 << r_bit);
    assign cand90    = r_v90 | (31'd1 << r_bit);
    assign scan_last = (CW'(r_j) == r_count - 1'b1);

    // Calibration result
    logic [31:0] iqr_c;
    logic [48:0] sc_sum;
    logic [32:0] sc_q;
    logic [31:0] sc_c;
    assign iqr_c  = (r_v90 > r_v10) ? 32'(r_v90 - r_v10) : 32'd0;
    assign sc_sum = {1'b0, r_acc} + {1'b0, r_prod[47:0]} + 49'd32768;
    assign sc_q   = sc_sum[48:16];
    assign sc_c   = (sc_q < 33'(SCALE_FLOOR)) ? SCALE_FLOOR
                  : (sc_q[32] ? 32'hFFFF_FFFF : sc_q[31:0]);

    // Running mean and centred return
    logic signed [33:0] r_sgn, dlt;
    logic signed [49:0] prod_s, step_s;
    logic signed [34:0] mean_w, cent;
    logic signed [31:0] mean_c;
    logic [31:0]        cmag, scale_eff;
    assign r_sgn  = r_rneg ? -$signed({3'b000, r_rmag}) : $signed({3'b000, r_rmag});
    assign dlt    = r_sgn - $signed({{2{r_mean[31]}}, r_mean});
    assign prod_s = r_dneg ? -$signed({2'b00, r_prod[47:0]}) : $signed({2'b00, r_prod[47:0]});
    assign step_s = (prod_s + 50'sd32768) >>> 16;
    assign mean_w = $signed({{3{r_mean[31]}}, r_mean}) + $signed(step_s[34:0]);
    assign mean_c = (mean_w > 35'sd2147483647)  ? 32'sh7FFF_FFFF
                  : (mean_w < -35'sd2147483648) ? 32'sh8000_0000
                  : mean_w[31:0];
    assign cent   = $signed({r_sgn[33], r_sgn}) - $signed({{3{r_mean[31]}}, r_mean});
    assign cmag   = cent[34] ? 32'(-cent) : 32'(cent);
    assign scale_eff = (r_scale < SCALE_FLOOR) ? SCALE_FLOOR : r_scale;

    // Shared restoring divider step
    logic [DEN_W:0] rem_sh;
    logic           div_ge;
    assign rem_sh = {r_rem[DEN_W-1:0], r_quo[DIV_W-1]};
    assign div_ge = (rem_sh >= {1'b0, r_den});

    // z clamp, gain and exponent
    logic [19:0] zq_c;
    logic [31:0] u_c;
    logic [47:0] y_c;
    logic [32:0] e_c;
    logic [33:0] one_pe;
    logic [48:0] tnum;
    assign zq_c   = (r_quo > DIV_W'(Z_MAX)) ? Z_MAX : r_quo[19:0];
    assign u_c    = 32'((r_prod[47:0] + 48'd32768) >> 16);
    assign y_c    = (r_prod[47:0] + 48'd32768) >> 16;
    assign e_c    = (r_n >= 16'd33) ? 33'd0 : (r_res >> r_n);
    assign one_pe = 34'h1_0000_0000 + 34'(e_c);
    assign tnum   = ({16'd0, 33'h1_0000_0000 - e_c} << 16) + 49'(one_pe >> 1);

    // Score path
    logic signed [25:0] t42, sig_c, prev, diff, dstep, delta, s_c, pdiff, s2, s_cl;
    logic signed [37:0] pull_p, pull_step;
    assign t42    = $signed(26'(r_quo[16:0]) * 26'd42);
    assign sig_c  = r_cneg ? SCORE_MID - t42 : SCORE_MID + t42;
    assign prev   = $signed({3'b000, r_held});
    assign diff   = r_sig - prev;
    assign dstep  = (diff + 26'sd2) >>> 2;
    assign delta  = (dstep > STEP_MAX) ? STEP_MAX : ((dstep < -STEP_MAX) ? -STEP_MAX : dstep);
    assign s_c    = prev + delta;
    assign pdiff  = SCORE_MID - r_s;
    assign pull_p = $signed({{12{pdiff[25]}}, pdiff}) * PULL_Q16;
    assign pull_step = (pull_p + 38'sd32768) >>> 16;
    assign s2     = r_near ? r_s + pull_step[25:0] : r_s;
    assign s_cl   = (s2 < SCORE_MIN) ? SCORE_MIN : ((s2 > SCORE_MAX) ? SCORE_MAX : s2);

    // Shared multiplier operands
    logic [31:0] mul_a, mul_b;
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (r_state)
            S_LOG_MUL:  begin mul_a = r_m;             mul_b = r_m;          end
            S_RET_MUL:  begin mul_a = r_dmag[31:0];    mul_b = LN2_Q30;      end
            S_CAL_MUL1: begin mul_a = r_sum;           mul_b = W_SUM_Q16;    end
            S_CAL_MUL2: begin mul_a = r_iqr;           mul_b = W_IQR_Q16;    end
            S_MEAN_MUL: begin mul_a = r_dabs;          mul_b = 32'(r_alpha); end
            S_U_MUL:    begin mul_a = 32'(zq_c);       mul_b = GAIN_Q16;     end
            S_Y_MUL:    begin mul_a = {u_c[30:0], 1'b0}; mul_b = LOG2E_Q16;  end
            S_EXP_MUL:  begin mul_a = r_res[31:0];     mul_b = EXP_ROOT[r_k]; end
            default:    begin mul_a = '0;              mul_b = '0;           end
        endcase
    end

    // Sequencer
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:      if (i_tick.valid) n_state = S_LOG_MUL;
            S_LOG_MUL:   n_state = S_LOG_FIX;
            S_LOG_FIX:   n_state = (r_it == 5'd0) ? S_LOG_DONE : S_LOG_MUL;
            S_LOG_DONE:  n_state = r_have_last ? S_RET_MUL : S_OUT;
            S_RET_MUL:   n_state = S_RET_FIX;
            S_RET_FIX:   n_state = S_WIN;
            S_WIN:       n_state = recal ? S_CAL_INIT : S_MEAN_SUB;
            S_CAL_INIT:  n_state = S_CAL_SCAN;
            S_CAL_SCAN:  if (scan_last) n_state = S_CAL_DRAIN;
            S_CAL_DRAIN: n_state = S_CAL_BIT;
            S_CAL_BIT:   n_state = (r_bit == 5'd0) ? S_CAL_SUM : S_CAL_SCAN;
            S_CAL_SUM:   n_state = S_CAL_MUL1;
            S_CAL_MUL1:  n_state = S_CAL_MUL2;
            S_CAL_MUL2:  n_state = S_CAL_DONE;
            S_CAL_DONE:  n_state = S_MEAN_SUB;
            S_MEAN_SUB:  n_state = S_MEAN_MUL;
            S_MEAN_MUL:  n_state = S_MEAN_ADD;
            S_MEAN_ADD:  n_state = S_CENT;
            S_CENT:      n_state = S_DIV;
            S_DIV:       if (r_dcnt == 6'd0) n_state = r_div_t ? S_SIG : S_U_MUL;
            S_U_MUL:     n_state = S_Y_MUL;
            S_Y_MUL:     n_state = S_EXP_INIT;
            S_EXP_INIT:  n_state = S_EXP_MUL;
            S_EXP_MUL:   n_state = S_EXP_FIX;
            S_EXP_FIX:   n_state = (r_k == 4'd0) ? S_EXP_END : S_EXP_MUL;
            S_EXP_END:   n_state = S_DIV;
            S_SIG:       n_state = S_STEP;
            S_STEP:      n_state = S_PULL;
            S_PULL:      n_state = S_OUT;
            S_OUT:       if (out_load) n_state = S_IDLE;
            default:     n_state = S_IDLE;
        endcase
    end

    // Window memory: write the new magnitude, read during the rank scan
    always_ff @(posedge i_clk) begin
        if (r_state == S_WIN) r_mem[r_head] <= r_rmag;
        if (r_state == S_CAL_SCAN) r_rd_data <= r_mem[r_j];
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_alpha      <= EMA_ALPHA_RST;
            r_period     <= RECAL_PERIOD_RST;
            r_have_last  <= 1'b0;
            r_count      <= '0;
            r_head       <= '0;
            r_ticks      <= '0;
            r_frozen     <= 1'b0;
            r_scale      <= 32'(INIT_SCALE_RST);
            r_mean       <= '0;
            r_held       <= INIT_SCORE_RST;
            r_rd_vld     <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_rd_vld <= (r_state == S_CAL_SCAN);

            // Register writes: user to keep them to idle, not enforced
            if (i_cfg.valid) begin
                case (i_cfg.index)
                    CFG_EMA_ALPHA: r_alpha <= i_cfg.wdata[15:0];
                    CFG_INIT_SCALE: begin
                        if (!r_have_last) r_scale <= {1'b0, i_cfg.wdata[30:0]};
                    end
                    CFG_INIT_SCORE: begin
                        if (!r_have_last) r_held <= i_cfg.wdata[22:0];
                    end
                    CFG_RECAL_PERIOD: r_period <= i_cfg.wdata[9:0];
                    default: r_period <= r_period;
                endcase
            end

            if (r_state == S_LOG_DONE) r_have_last <= 1'b1;

            // Advance the ring window and the calibration schedule
            if (r_state == S_WIN) begin
                r_head  <= (r_head == LAST_ADDR) ? '0 : r_head + 1'b1;
                r_count <= n_cnt;
                if (!r_frozen) begin
                    r_ticks <= recal ? 10'd0 : n_tick;
                    if (recal && (n_cnt == DEPTH_C)) r_frozen <= 1'b1;
                end
            end

            if (r_state == S_CAL_DONE) r_scale <= sc_c;
            if (r_state == S_MEAN_ADD) r_mean <= mean_c;
            if (r_state == S_PULL) r_held <= s_cl[22:0];

            // Hold the result until taken
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        r_prod <= mul_a * mul_b;

        if (out_load) begin
            r_out_score  <= r_held;
            r_out_frozen <= r_frozen;
        end

        case (r_state)
            S_IDLE: begin
                if (tick_acc) begin
                    r_m    <= m0;
                    r_exp5 <= lead;
                    r_frac <= '0;
                    r_it   <= 5'd27;
                end
            end
            S_LOG_FIX: begin
                if (sq[32]) begin
                    r_m <= sq[32:1];
                    r_frac[r_it] <= 1'b1;
                end else begin
                    r_m <= sq[31:0];
                end
                if (r_it != 5'd0) r_it <= r_it - 5'd1;
            end
            S_LOG_DONE: begin
                r_dmag     <= dmag_c;
                r_rneg     <= (lb < r_last_log);
                r_last_log <= lb;
            end
            S_RET_FIX: begin
                r_rmag <= (ret_q > 34'h0_7FFF_FFFF) ? 31'h7FFF_FFFF : ret_q[30:0];
            end
            S_CAL_INIT: begin
                r_i10    <= i10_c;
                r_i90    <= i90_c;
                r_v10    <= '0;
                r_v90    <= '0;
                r_bit    <= 5'd30;
                r_j      <= '0;
                r_less10 <= '0;
                r_less90 <= '0;
            end
            S_CAL_SCAN: begin
                if (!scan_last) r_j <= r_j + 1'b1;
            end
            S_CAL_BIT: begin
                if (r_less10 <= r_i10) r_v10 <= cand10;
                if (r_less90 <= r_i90) r_v90 <= cand90;
                r_less10 <= '0;
                r_less90 <= '0;
                r_j      <= '0;
                if (r_bit != 5'd0) r_bit <= r_bit - 5'd1;
            end
            S_CAL_SUM: begin
                r_sum <= 32'(r_v90) + 32'(r_v10);
                r_iqr <= (iqr_c < SCALE_FLOOR) ? SCALE_FLOOR : iqr_c;
            end
            S_CAL_MUL2: r_acc <= r_prod[47:0];
            S_MEAN_SUB: begin
                r_dneg <= dlt[33];
                r_dabs <= dlt[33] ? 32'(-dlt) : 32'(dlt);
            end
            S_CENT: begin
                r_cneg  <= cent[34];
                r_quo   <= {1'b0, cmag, 16'd0} + 49'(scale_eff >> 1);
                r_den   <= DEN_W'(scale_eff);
                r_rem   <= '0;
                r_dcnt  <= 6'(DIV_W - 1);
                r_div_t <= 1'b0;
            end
            S_DIV: begin
                r_rem <= div_ge ? rem_sh - {1'b0, r_den} : rem_sh;
                r_quo <= {r_quo[DIV_W-2:0], div_ge};
                if (r_dcnt != 6'd0) r_dcnt <= r_dcnt - 6'd1;
            end
            S_EXP_INIT: begin
                r_n   <= y_c[31:16];
                r_f   <= y_c[15:0];
                r_res <= 33'h1_0000_0000;
                r_k   <= 4'd15;
            end
            S_EXP_FIX: begin
                if (r_f[r_k]) begin
                    r_res <= r_res[32] ? {1'b0, EXP_ROOT[r_k]} : {1'b0, r_prod[63:32]};
                end
                if (r_k != 4'd0) r_k <= r_k - 4'd1;
            end
            S_EXP_END: begin
                r_quo   <= tnum;
                r_den   <= DEN_W'(one_pe);
                r_rem   <= '0;
                r_dcnt  <= 6'(DIV_W - 1);
                r_div_t <= 1'b1;
            end
            S_SIG: r_sig <= sig_c;
            S_STEP: begin
                r_s    <= s_c;
                r_near <= ((r_sig - SCORE_MID) < STEP_MAX) && ((SCORE_MID - r_sig) < STEP_MAX);
            end
            default: r_m <= r_m;
        endcase

        // Count window entries below each candidate
        if (r_rd_vld) begin
            if (r_rd_data < cand10) r_less10 <= r_less10 + 1'b1;
            if (r_rd_data < cand90) r_less90 <= r_less90 + 1'b1;
        end
    end

`ifndef SYNTHESIS
    a_frozen_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_frozen |=> r_frozen)
        else $error("calibration unfroze");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= DEPTH_C)
        else $error("window count beyond depth");

    a_head_tracks_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count != DEPTH_C) |-> (CW'(r_head) == r_count))
        else $error("window head and fill count disagree");

    a_scale_floor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CAL_DONE) |=> (r_scale >= SCALE_FLOOR))
        else $error("calibrated scale below floor");

    a_score_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PULL) |=> ((r_held >= 23'(SCORE_MIN)) && (r_held <= 23'(SCORE_MAX))))
        else $error("held score out of range");
`endif

endmodule

>>> tb/sv/return_score_checker.sv
`timescale 1ns / 100ps
// Scoreboard for the return score conditioner: watches the tick, config and
// result channels, predicts each score and compares. Depends on rcs_pkg, rcs_if.
module return_score_checker import rcs_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    rcs_tick_if       tick,
    rcs_cfg_if        cfg,
    rcs_result_if     res,
    output int        o_errors,
    output int        o_outstanding
);
    typedef struct packed {
        logic [22:0] score;
        logic        frozen;
    } t_dial;

    localparam int DEPTH = 256;
    localparam int PEND_DEPTH = 8;

    t_dial       pend[PEND_DEPTH];
    int          wr_cnt;
    int          rd_cnt;
    logic [15:0] alpha_r;
    logic [9:0]  period_r;
    logic [31:0] prev_price;
    logic        seen_tick;
    logic [31:0] abs_win[DEPTH];
    int          fill;
    int          head;
    logic [9:0]  since_cal;
    logic        frozen;
    logic [31:0] scale_r;
    longint      mean_r;
    longint      dial_r;
    int          errors;

    assign o_errors      = errors;
    assign o_outstanding = wr_cnt - rd_cnt;

    function automatic longint floor_shift(input longint x, input int s);
        return (x + (longint'(1) << (s - 1))) >>> s;
    endfunction

    function automatic logic [63:0] int_sqrt(input logic [63:0] v);
        logic [63:0] r;
        logic [63:0] b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    // log2 in Q5.28 by repeated truncated squaring
    function automatic logic [63:0] log2_fix(input logic [31:0] x);
        int          e;
        logic [63:0] m;
        logic [63:0] frac;
        e = 31;
        frac = 0;
        while (!x[e]) e--;
        m = 64'(x) << (31 - e);
        for (int i = 27; i >= 0; i--) begin
            m = (m * m) >> 31;
            if (m >= (64'd1 << 32)) begin
                m = m >> 1;
                frac[i] = 1'b1;
            end
        end
        return (64'(e) << 28) | frac;
    endfunction

    // exp(-x) in Q0.32, x in Q16
    function automatic logic [63:0] exp_neg_q32(input logic [63:0] x);
        logic [63:0] y;
        logic [63:0] n;
        logic [63:0] f;
        logic [63:0] acc;
        logic [63:0] c;
        y = (x * 94548 + 32768) >> 16;
        n = y >> 16;
        f = y & 64'hFFFF;
        acc = 64'd1 << 32;
        c = int_sqrt(64'd1 << 63);
        for (int k = 15; k >= 0; k--) begin
            if (f[k]) acc = (acc * c) >> 32;
            c = int_sqrt(c << 32);
        end
        if (n >= 33) return 0;
        return acc >> n;
    endfunction

    // rank-th smallest of the filled window entries
    function automatic logic [31:0] rank_value(input int rank);
        logic [31:0] v;
        logic [31:0] cand;
        int          less;
        v = 0;
        for (int b = 30; b >= 0; b--) begin
            cand = v | (32'd1 << b);
            less = 0;
            for (int j = 0; j < fill; j++)
                if (abs_win[j] < cand) less++;
            if (less <= rank) v = cand;
        end
        return v;
    endfunction

    function automatic void recalibrate_scale();
        int          lo_rank;
        int          hi_rank;
        logic [31:0] p10;
        logic [31:0] p90;
        logic [63:0] spread;
        logic [63:0] sc;
        if (fill == 0) return;
        lo_rank = fill * 10 / 100;
        hi_rank = fill * 90 / 100;
        if (hi_rank > fill - 1) hi_rank = fill - 1;
        p10 = rank_value(lo_rank);
        p90 = rank_value(hi_rank);
        spread = (p90 > p10) ? 64'(p90 - p10) : 0;
        if (spread < 3) spread = 3;
        sc = (64'd48582 * (64'(p90) + 64'(p10)) + 64'd16954 * spread + 32768) >> 16;
        if (sc < 3) sc = 3;
        if (sc > 64'hFFFFFFFF) sc = 64'hFFFFFFFF;
        scale_r = sc[31:0];
    endfunction

    // Advance the model by one tick and return the expected result
    function automatic t_dial predict_dial(input logic [31:0] price_in);
        logic [31:0] price;
        logic [63:0] la;
        logic [63:0] lb;
        logic [63:0] dmag;
        logic [63:0] rmag;
        logic [63:0] cmag;
        logic [63:0] zq;
        logic [63:0] u;
        logic [63:0] e;
        logic [63:0] t;
        logic [63:0] sc;
        longint      r;
        longint      m;
        longint      centered;
        longint      sig;
        longint      delta;
        longint      s;
        t_dial       d;
        price = (price_in == 0) ? 32'd1 : price_in;
        if (seen_tick) begin
            la = log2_fix(prev_price);
            lb = log2_fix(price);
            dmag = (lb >= la) ? lb - la : la - lb;
            rmag = (dmag * 64'd744261118 + (64'd1 << 29)) >> 30;
            if (rmag > 64'h7FFFFFFF) rmag = 64'h7FFFFFFF;
            r = (lb >= la) ? longint'(rmag) : -longint'(rmag);
            abs_win[head] = rmag[31:0];
            head = (head + 1) % DEPTH;
            if (fill < DEPTH) fill++;
            if (!frozen) begin
                if (since_cal < 10'd1023) since_cal++;
                if (fill >= DEPTH || since_cal >= period_r) begin
                    recalibrate_scale();
                    since_cal = 0;
                    if (fill >= DEPTH) frozen = 1'b1;
                end
            end
            m = mean_r + floor_shift((r - mean_r) * longint'(alpha_r), 16);
            if (m > 64'sd2147483647) m = 64'sd2147483647;
            if (m < -64'sd2147483648) m = -64'sd2147483648;
            mean_r = m;
            centered = r - m;
            sc = (scale_r < 3) ? 64'd3 : 64'(scale_r);
            cmag = (centered >= 0) ? 64'(centered) : 64'(-centered);
            zq = ((cmag << 16) + sc / 2) / sc;
            if (zq > 64'd524288) zq = 64'd524288;
            u = (zq * 29491 + 32768) >> 16;
            e = exp_neg_q32(2 * u);
            t = (((64'd1 << 32) - e) * 65536 + (((64'd1 << 32) + e) >> 1))
                / ((64'd1 << 32) + e);
            sig = (centered >= 0) ? 3276800 + 42 * longint'(t)
                                  : 3276800 - 42 * longint'(t);
            delta = floor_shift(sig - dial_r, 2);
            if (delta > 196608) delta = 196608;
            if (delta < -196608) delta = -196608;
            s = dial_r + delta;
            if (sig - 3276800 < 196608 && 3276800 - sig < 196608)
                s = s + floor_shift((3276800 - s) * 1966, 16);
            if (s < 131072) s = 131072;
            if (s > 6422528) s = 6422528;
            dial_r = s;
        end
        prev_price = price;
        seen_tick = 1'b1;
        d.score = dial_r[22:0];
        d.frozen = frozen;
        return d;
    endfunction

    // Track config, predict on tick transactions, compare result transactions
    always @(posedge i_clk) begin
        t_dial want;
        if (!i_rst_n) begin
            alpha_r      <= EMA_ALPHA_RST;
            period_r     <= RECAL_PERIOD_RST;
            prev_price   = 0;
            seen_tick    = 1'b0;
            fill         = 0;
            head         = 0;
            since_cal    = 0;
            frozen       = 1'b0;
            scale_r      = 32'(INIT_SCALE_RST);
            mean_r       = 0;
            dial_r       = longint'(INIT_SCORE_RST);
            errors       <= 0;
            wr_cnt       = 0;
            rd_cnt       = 0;
        end else begin
            if (cfg.valid && cfg.ready) begin
                case (cfg.index)
                    CFG_EMA_ALPHA: begin
                        alpha_r <= cfg.wdata[15:0];
                    end
                    CFG_INIT_SCALE: begin
                        if (!seen_tick) scale_r = 32'(cfg.wdata[30:0]);
                    end
                    CFG_INIT_SCORE: begin
                        if (!seen_tick) dial_r = longint'(cfg.wdata[22:0]);
                    end
                    CFG_RECAL_PERIOD: begin
                        period_r <= cfg.wdata[9:0];
                    end
                    default: ;
                endcase
            end
            if (res.valid && res.ready) begin
                if (wr_cnt == rd_cnt) begin
                    errors <= errors + 1;
                    if (errors < 10)
                        $display("unexpected result score=%0d frozen=%0b",
                                 res.score, res.scale_frozen);
                end else begin
                    want = pend[rd_cnt % PEND_DEPTH];
                    rd_cnt = rd_cnt + 1;
                    if (res.score !== want.score || res.scale_frozen !== want.frozen) begin
                        errors <= errors + 1;
                        if (errors < 10)
                            $display("result: expected score=%0d frozen=%0b, got score=%0d frozen=%0b",
                                     want.score, want.frozen, res.score, res.scale_frozen);
                    end
                end
            end
            if (tick.valid && tick.ready) begin
                pend[wr_cnt % PEND_DEPTH] = predict_dial(tick.price);
                wr_cnt = wr_cnt + 1;
            end
        end
    end
endmodule

>>> tb/sv/return_score_conditioner_test.sv
`timescale 1ns / 100ps
// Top of the return score conditioner testbench: clock, reset, price and
// config stimulus, result back-pressure and verdict. Depends on rcs_pkg,
// rcs_if, return_score_checker and the block itself.
module return_score_conditioner_test import rcs_pkg::*;;
    logic i_clk;
    logic i_rst_n;
    int   errors;
    int   outstanding;
    logic quiet;
    longint walk_price;

    rcs_tick_if   tick();
    rcs_cfg_if    cfg();
    rcs_result_if res();

    return_score_conditioner DUT (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_tick   (tick),
        .i_cfg    (cfg),
        .o_result (res)
    );

    return_score_checker SCB (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .tick          (tick),
        .cfg           (cfg),
        .res           (res),
        .o_errors      (errors),
        .o_outstanding (outstanding)
    );

    always begin
        i_clk = 1'b1;
        #1;
        i_clk = 1'b0;
        #1;
    end

    // Gap length: mostly none or short, a few long
    function automatic int idle_len();
        int pick;
        pick = $urandom_range(0, 99);
        if (quiet || pick < 55) return 0;
        if (pick < 90) return $urandom_range(1, 4);
        return $urandom_range(20, 400);
    endfunction

    // Randomly stall the result side
    always @(posedge i_clk) begin
        int hold;
        if (!i_rst_n) begin
            res.ready <= 1'b0;
        end else if (hold > 0) begin
            hold = hold - 1;
        end else begin
            hold = idle_len();
            res.ready <= (hold == 0) || !res.ready;
        end
    end

    task automatic send_tick(input logic [31:0] p);
        int gap;
        gap = idle_len();
        if (gap > 0) begin
            tick.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        tick.valid <= 1'b1;
        tick.price <= p;
        do @(posedge i_clk); while (!tick.ready);
    endtask

    task automatic write_reg(input t_cfg_index idx, input logic [31:0] data);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.wdata <= data;
        do @(posedge i_clk); while (!cfg.ready);
        cfg.valid <= 1'b0;
    endtask

    // Drop valid and wait until every predicted result has come back
    task automatic drain();
        tick.valid <= 1'b0;
        @(posedge i_clk);
        while (outstanding != 0) @(posedge i_clk);
    endtask

    // Mostly a random walk, with jumps and the price extremes mixed in
    function automatic logic [31:0] next_price();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 80) begin
            walk_price = walk_price
                         + (walk_price * (longint'($urandom_range(0, 400)) - 200)) / 10000
                         + longint'($urandom_range(0, 2)) - 1;
        end else if (pick < 88) begin
            walk_price = $urandom_range(1, 2000000);
        end else if (pick < 96) begin
            return $urandom;
        end else begin
            case ($urandom_range(0, 2))
                0: return 32'd0;
                1: return 32'd1;
                default: return 32'hFFFFFFFF;
            endcase
        end
        if (walk_price < 1) walk_price = 1;
        if (walk_price > 64'hFFFFFFFF) walk_price = 64'hFFFFFFFF;
        return walk_price[31:0];
    endfunction

    task automatic random_ticks(input int n);
        for (int i = 0; i < n; i++) begin
            if (i % 150 == 0) quiet = ($urandom_range(0, 3) == 0);
            send_tick(next_price());
        end
        quiet = 1'b0;
    endtask

    initial begin
        logic [31:0] edge_prices[20];
        edge_prices = '{32'd1, 32'd0, 32'hFFFFFFFF, 32'd1, 32'hFFFFFFFF, 32'h80000000,
                        32'h7FFFFFFF, 32'd2, 32'd3, 32'd1000, 32'd1001, 32'd999, 32'd1000,
                        32'd1000, 32'hAAAAAAAA, 32'h55555555, 32'd100, 32'd100,
                        32'hFFFFFFFE, 32'd1};
        quiet = 1'b0;
        walk_price = 100000;
        i_rst_n = 1'b0;
        tick.valid <= 1'b0;
        tick.price <= '0;
        cfg.valid <= 1'b0;
        cfg.index <= CFG_EMA_ALPHA;
        cfg.wdata <= '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Extremes before the first tick: out-of-range score, tiny scale, zero period
        write_reg(CFG_EMA_ALPHA, 32'hFFFF);
        write_reg(CFG_INIT_SCALE, 32'd3);
        write_reg(CFG_INIT_SCALE, 32'd0);
        write_reg(CFG_INIT_SCORE, 32'h7FFFFF);
        write_reg(CFG_RECAL_PERIOD, 32'd0);
        foreach (edge_prices[i]) send_tick(edge_prices[i]);
        drain();

        write_reg(CFG_EMA_ALPHA, 32'd1);
        write_reg(CFG_INIT_SCALE, 32'h7FFFFFFF);
        write_reg(CFG_INIT_SCORE, 32'd131072);
        write_reg(CFG_RECAL_PERIOD, 32'd1023);
        random_ticks(400);
        drain();

        write_reg(CFG_EMA_ALPHA, 32'd655);
        write_reg(CFG_INIT_SCALE, 32'd268435);
        write_reg(CFG_INIT_SCORE, 32'd6422528);
        write_reg(CFG_RECAL_PERIOD, 32'd50);
        random_ticks(450);
        drain();

        write_reg(CFG_EMA_ALPHA, $urandom_range(1, 65535));
        write_reg(CFG_RECAL_PERIOD, 32'd1);
        random_ticks(430);
        drain();

        repeat (300) @(posedge i_clk);
        if (errors == 0 && outstanding == 0)
            $display("return_score_conditioner: match");
        else
            $display("return_score_conditioner: mismatch");
        $finish;
    end

    initial begin
        #20000000;
        $display("return_score_conditioner: mismatch");
        $finish;
    end
endmodule
